[rtl/tmtw_pkg.sv]
`timescale 1ns / 1ps

package tmtw_pkg;

  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] BLANK_BYTE   = 8'h20;
  localparam logic [7:0] PRINT_LO     = 8'h20;
  localparam logic [7:0] PRINT_HI     = 8'h7E;
  localparam logic [7:0] RESET_ATTR   = 8'h07;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       is_newline;
    logic       is_print;
    logic       rd_ok;
    logic [4:0] rd_row;
    logic [6:0] rd_col;
  } cmd_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  row;
    logic [6:0]  col;
  } res_t;

endpackage

[rtl/tmtw_front.sv]
`timescale 1ns / 1ps

module tmtw_front import tmtw_pkg::*; #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       hold,
  output logic       full,
  input  logic [1:0] kind,
  input  logic [7:0] char_code,
  input  logic [4:0] read_row,
  input  logic [6:0] read_col,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output cmd_t       cmd
);

  logic accept;
  cmd_t cmd_next;

  assign full   = hold || (cmd_valid && !cmd_ready);
  assign accept = push && !full;

  always_comb begin
    cmd_next.kind       = kind;
    cmd_next.ch         = char_code;
    cmd_next.is_newline = (char_code == NEWLINE_BYTE);
    cmd_next.is_print   = (char_code >= PRINT_LO) && (char_code <= PRINT_HI);
    cmd_next.rd_ok      = ({2'b00, read_row} < 7'(ROWS)) &&
                          ({1'b0, read_col} < 8'(COLUMNS));
    cmd_next.rd_row     = read_row;
    cmd_next.rd_col     = read_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_next;
    end
  end

endmodule

[rtl/tmtw_queue.sv]
`timescale 1ns / 1ps

module tmtw_queue import tmtw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic out_valid,
  input  logic out_pop,
  output cmd_t out_cmd
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   count;
  logic          wr_en;
  logic          rd_en;

  assign in_ready  = (count != (PW+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign wr_en     = in_valid && in_ready;
  assign rd_en     = out_pop && out_valid;
  assign out_cmd   = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= rptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wptr] <= in_cmd;
    end
  end

endmodule

[rtl/tmtw_back.sv]
`timescale 1ns / 1ps

module tmtw_back import tmtw_pkg::*; #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_pop,
  input  cmd_t       cmd,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output logic       init_busy,
  output logic       res_valid,
  input  logic       res_pop,
  output res_t       res
);

  localparam int RW        = $clog2(ROWS);
  localparam int CI        = $clog2(COLUMNS);
  localparam int CW        = $clog2(COLUMNS + 1);
  localparam int AW        = RW + CI;
  localparam int MEM_DEPTH = 2 ** AW;

  localparam logic [RW:0]   ROWS_W   = (RW+1)'(ROWS);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [CI-1:0] LAST_COL = CI'(COLUMNS - 1);
  localparam logic [CW-1:0] WRAP_COL = CW'(COLUMNS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_BLANK  = 3'd2;
  localparam logic [2:0] ST_WRITE  = 3'd3;
  localparam logic [2:0] ST_RDATA  = 3'd4;
  localparam logic [2:0] ST_FILL   = 3'd5;

  logic [2:0]    state;
  cmd_t          cur;
  logic [RW-1:0] crow;
  logic [CW-1:0] ccol;
  logic [RW-1:0] top;
  logic [RW-1:0] top_next;
  logic [7:0]    attr;
  logic [RW-1:0] swp_row;
  logic [CI-1:0] swp_col;
  logic [15:0]   fill;
  logic          fill_res;
  logic [CW-1:0] col_after;
  logic          wrap;

  logic [15:0]   mem [MEM_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   rd_data;

  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r,
                                             input logic [RW-1:0] t);
    logic [RW:0] s;
    s = {1'b0, r} + {1'b0, t};
    if (s >= ROWS_W) begin
      s = s - ROWS_W;
    end
    return s[RW-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign init_busy = (state == ST_FILL) && !fill_res;
  assign cmd_pop   = (state == ST_IDLE) && cmd_valid && !res_valid;
  assign top_next  = (top == LAST_ROW) ? '0 : top + 1'b1;
  assign wrap      = cur.is_newline || (ccol >= WRAP_COL);
  assign col_after = ccol + CW'(cur.is_print);
  assign mem_raddr = {phys_row(RW'(cur.rd_row), top), cur.rd_col[CI-1:0]};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {swp_row, swp_col};
    mem_wdata = fill;
    case (state)
      ST_FILL: begin
        mem_we = 1'b1;
      end
      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_wdata = {attr, BLANK_BYTE};
      end
      ST_WRITE: begin
        mem_we    = cur.is_print;
        mem_waddr = {phys_row(crow, top), ccol[CI-1:0]};
        mem_wdata = {attr, cur.ch};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      crow      <= '0;
      ccol      <= '0;
      top       <= '0;
      attr      <= RESET_ATTR;
      swp_row   <= '0;
      swp_col   <= '0;
      fill      <= {RESET_ATTR, BLANK_BYTE};
      fill_res  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        attr <= cfg_data;
      end
      if (res_valid && res_pop) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          case (cur.kind)
            KIND_PUT: begin
              if (wrap) begin
                ccol <= '0;
                if (crow == LAST_ROW) begin
                  top     <= top_next;
                  swp_row <= top;
                  swp_col <= '0;
                  state   <= ST_BLANK;
                end else begin
                  crow  <= crow + 1'b1;
                  state <= ST_WRITE;
                end
              end else begin
                state <= ST_WRITE;
              end
            end
            KIND_READ: begin
              state <= ST_RDATA;
            end
            KIND_CLEAR: begin
              fill     <= {attr, BLANK_BYTE};
              fill_res <= 1'b1;
              swp_row  <= '0;
              swp_col  <= '0;
              crow     <= '0;
              ccol     <= '0;
              top      <= '0;
              state    <= ST_FILL;
            end
            default: begin
              res       <= '{cell_value: 16'h0000, row: 5'(crow), col: 7'(ccol)};
              res_valid <= 1'b1;
              state     <= ST_IDLE;
            end
          endcase
        end
        ST_BLANK: begin
          swp_col <= swp_col + 1'b1;
          if (swp_col == LAST_COL) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          ccol      <= col_after;
          res       <= '{cell_value: 16'h0000, row: 5'(crow), col: 7'(col_after)};
          res_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        ST_RDATA: begin
          res       <= '{cell_value: (cur.rd_ok ? rd_data : 16'h0000),
                         row: 5'(crow), col: 7'(ccol)};
          res_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        ST_FILL: begin
          if (swp_col == LAST_COL) begin
            swp_col <= '0;
            swp_row <= swp_row + 1'b1;
            if (swp_row == LAST_ROW) begin
              state <= ST_IDLE;
              if (fill_res) begin
                res       <= '{cell_value: 16'h0000, row: 5'(crow), col: 7'(ccol)};
                res_valid <= 1'b1;
              end
              fill_res <= 1'b0;
            end
          end else begin
            swp_col <= swp_col + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/text_mode_terminal_writer.sv]
`timescale 1ns / 1ps
// Each item is popped in IDLE; a put then passes DECIDE and WRITE, a read DECIDE and RDATA,
// and an unused one only DECIDE before its result is registered; a put that scrolls first
// blanks the new last row in BLANK and a clear refills every cell in FILL, both through the
// single write port of the screen memory. The executor handles one item at a time and
// takes the next only once the previous result has been taken; up to three items wait in
// the front register and queue.
// After rst the screen memory is filled with blank cells in FILL, with full held.

module text_mode_terminal_writer import tmtw_pkg::*; #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind,
  input  logic [7:0]  char_code,
  input  logic [4:0]  read_row,
  input  logic [6:0]  read_col,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] cell_value,
  output logic [4:0]  cursor_row,
  output logic [6:0]  cursor_col,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  cmd_t front_cmd;
  cmd_t queue_cmd;
  res_t res;
  logic front_valid;
  logic queue_ready;
  logic queue_valid;
  logic queue_pop;
  logic init_busy;
  logic res_valid;

  tmtw_front #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .hold      (init_busy),
    .full      (full),
    .kind      (kind),
    .char_code (char_code),
    .read_row  (read_row),
    .read_col  (read_col),
    .cmd_valid (front_valid),
    .cmd_ready (queue_ready),
    .cmd       (front_cmd)
  );

  tmtw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (queue_ready),
    .in_cmd    (front_cmd),
    .out_valid (queue_valid),
    .out_pop   (queue_pop),
    .out_cmd   (queue_cmd)
  );

  tmtw_back #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (queue_valid),
    .cmd_pop   (queue_pop),
    .cmd       (queue_cmd),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .init_busy (init_busy),
    .res_valid (res_valid),
    .res_pop   (pop),
    .res       (res)
  );

  assign empty      = !res_valid;
  assign cell_value = res.cell_value;
  assign cursor_row = res.row;
  assign cursor_col = res.col;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import tmtw_pkg::*;

  localparam int ROWS = 25;
  localparam int COLUMNS = 80;
  localparam int CELLS = ROWS * COLUMNS;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 20000000;
  localparam int HOLD_AT = 600;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_FROM = 1000;
  localparam int QUIET_TO = 1300;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [4:0] row;
    logic [6:0] col;
  } term_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [1:0] kind = '0;
  logic [7:0] char_code = '0;
  logic [4:0] read_row = '0;
  logic [6:0] read_col = '0;
  logic empty;
  logic pop = 1'b0;
  logic [15:0] cell_value;
  logic [4:0] cursor_row;
  logic [6:0] cursor_col;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;

  term_item_t queued_commands[$];
  res_t expected_status[$];
  term_item_t offered;
  logic command_taken = 1'b0;
  int commands_sent = 0;
  int results_seen = 0;
  int errors = 0;
  int cycle_count = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;

  logic [15:0] screen_model[CELLS];
  int cur_row;
  int cur_col;
  logic [7:0] attribute;

  text_mode_terminal_writer #(
    .ROWS(ROWS),
    .COLUMNS(COLUMNS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .kind(kind),
    .char_code(char_code),
    .read_row(read_row),
    .read_col(read_col),
    .empty(empty),
    .pop(pop),
    .cell_value(cell_value),
    .cursor_row(cursor_row),
    .cursor_col(cursor_col),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void blank_screen_row(input int r);
    int x;
    for (x = 0; x < COLUMNS; x++) begin
      screen_model[r * COLUMNS + x] = {attribute, BLANK_BYTE};
    end
  endfunction

  function automatic void apply_command(input term_item_t it);
    res_t r;
    int i;
    r.cell_value = '0;
    case (it.kind)
      KIND_PUT: begin
        if (it.ch == NEWLINE_BYTE || cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
          if (cur_row >= ROWS) begin
            for (i = 0; i + COLUMNS < CELLS; i++) begin
              screen_model[i] = screen_model[i + COLUMNS];
            end
            cur_row = ROWS - 1;
            blank_screen_row(cur_row);
          end
        end
        if (it.ch >= PRINT_LO && it.ch <= PRINT_HI) begin
          screen_model[cur_row * COLUMNS + cur_col] = {attribute, it.ch};
          cur_col++;
        end
      end
      KIND_READ: begin
        if (it.row < ROWS && it.col < COLUMNS) begin
          r.cell_value = screen_model[it.row * COLUMNS + it.col];
        end
      end
      KIND_CLEAR: begin
        for (i = 0; i < ROWS; i++) begin
          blank_screen_row(i);
        end
        cur_row = 0;
        cur_col = 0;
      end
      default: begin
      end
    endcase
    r.row = 5'(cur_row);
    r.col = 7'(cur_col);
    expected_status.push_back(r);
  endfunction

  // Driver: offers the next queued command once the previous one has transferred.
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || command_taken) begin
      if (queued_commands.size() > 0 &&
          ((commands_sent >= QUIET_FROM && commands_sent < QUIET_TO) ||
           $urandom_range(99) >= 10)) begin
        offered = queued_commands.pop_front();
        commands_sent++;
        push <= 1'b1;
        kind <= offered.kind;
        char_code <= offered.ch;
        read_row <= offered.row;
        read_col <= offered.col;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off so the input side backs up.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      pop <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      pop <= (results_seen >= QUIET_FROM && results_seen < QUIET_TO) ||
             $urandom_range(99) >= 10;
    end
  end

  // Monitor: predicts on each input transfer and checks each result transfer.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      command_taken <= 1'b0;
    end else begin
      command_taken <= push && !full;
      if (push && !full) begin
        apply_command(offered);
      end
      if (pop && !empty) begin
        results_seen++;
        if (expected_status.size() == 0) begin
          $error("unexpected result: cell_value %h cursor_row %0d cursor_col %0d",
                 cell_value, cursor_row, cursor_col);
          errors++;
        end else begin
          want = expected_status.pop_front();
          if (cell_value !== want.cell_value) begin
            $error("cell_value: expected %h, actual %h", want.cell_value, cell_value);
            errors++;
          end
          if (cursor_row !== want.row) begin
            $error("cursor_row: expected %0d, actual %0d", want.row, cursor_row);
            errors++;
          end
          if (cursor_col !== want.col) begin
            $error("cursor_col: expected %0d, actual %0d", want.col, cursor_col);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic add_item(input logic [1:0] k, input logic [7:0] c,
                          input logic [4:0] r, input logic [6:0] cl);
    term_item_t it;
    it.kind = k;
    it.ch = c;
    it.row = r;
    it.col = cl;
    queued_commands.push_back(it);
  endtask

  task automatic add_put(input logic [7:0] c);
    add_item(KIND_PUT, c, 5'($urandom), 7'($urandom));
  endtask

  task automatic add_read(input logic [4:0] r, input logic [6:0] c);
    add_item(KIND_READ, 8'($urandom), r, c);
  endtask

  task automatic wait_idle();
    while (queued_commands.size() > 0 || push || expected_status.size() > 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    attribute = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly lines of printable text ended by newlines, with reads, stray bytes,
  // unused commands and the odd clear mixed in.
  task automatic add_text_session(input int n);
    int left;
    int len;
    int pick;
    int i;
    left = n;
    while (left > 0) begin
      pick = $urandom_range(199);
      if (pick < 110) begin
        len = ($urandom_range(9) == 0) ? COLUMNS - 2 + $urandom_range(4) : $urandom_range(12);
        for (i = 0; i < len; i++) begin
          add_put(8'($urandom_range(PRINT_LO, PRINT_HI)));
        end
        left -= len;
        if ($urandom_range(4) != 0) begin
          add_put(NEWLINE_BYTE);
          left--;
        end
      end else if (pick < 160) begin
        if ($urandom_range(6) == 0) begin
          add_read(5'($urandom), 7'($urandom));
        end else begin
          add_read(5'($urandom_range(ROWS - 1)), 7'($urandom_range(COLUMNS - 1)));
        end
        left--;
      end else if (pick < 176) begin
        add_put(8'($urandom));
        left--;
      end else if (pick < 190) begin
        add_put(NEWLINE_BYTE);
        left--;
      end else if (pick < 198) begin
        add_item(KIND_UNUSED, 8'($urandom), 5'($urandom), 7'($urandom));
        left--;
      end else begin
        add_item(KIND_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
        left--;
      end
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < CELLS; i++) begin
      screen_model[i] = 16'h0720;
    end
    cur_row = 0;
    cur_col = 0;
    attribute = RESET_ATTR;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_read(5'd0, 7'd0);
    add_read(5'd24, 7'd79);
    add_read(5'd25, 7'd0);
    add_read(5'd31, 7'd127);
    add_read(5'd0, 7'd80);
    add_put(8'h41);
    add_put(BLANK_BYTE);
    add_put(PRINT_HI);
    add_put(8'h7F);
    add_put(8'h1F);
    add_put(8'h00);
    add_put(8'hFF);
    add_put(8'h80);
    add_read(5'd0, 7'd0);
    add_read(5'd0, 7'd2);
    add_put(NEWLINE_BYTE);
    add_put(NEWLINE_BYTE);
    add_item(KIND_UNUSED, 8'hFF, 5'd31, 7'd127);
    add_item(KIND_UNUSED, 8'h00, 5'd0, 7'd0);
    add_item(KIND_CLEAR, 8'h00, 5'd0, 7'd0);
    add_read(5'd0, 7'd0);
    add_put(8'h5A);
    add_read(5'd0, 7'd0);
    wait_idle();

    write_attribute(8'h00);
    add_text_session(410);
    wait_idle();

    write_attribute(8'hFF);
    add_text_session(410);
    wait_idle();

    write_attribute(8'($urandom));
    add_text_session(410);
    wait_idle();

    write_attribute(8'($urandom));
    add_text_session(410);
    wait_idle();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
